// ===== rtl/core/uniform_mod_q_rejection_sampler_assert.svh =====
// Assertion macros used by the rejection sampler queue.
`ifndef UNIFORM_MOD_Q_REJECTION_SAMPLER_ASSERT_SVH
`define UNIFORM_MOD_Q_REJECTION_SAMPLER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define UMQRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define UMQRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/umqrs_pkg.sv =====
// Shared types and constants of the uniform mod-q rejection sampler.
package umqrs_pkg;

  localparam int MAX_COEFFS  = 256;
  localparam int MOD_W       = 13;
  localparam int CNT_W       = 9;
  localparam int COEFF_W     = 12;
  localparam int INDEX_W     = 8;
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 13;

  localparam logic [MOD_W-1:0] MODULUS_RESET = 13'd3329;
  localparam logic [CNT_W-1:0] COUNT_RESET   = 9'd256;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_COUNT = 1'b1;

  // Queue depth must be a power of two (pointers wrap naturally).
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [COEFF_W-1:0] coeff;
    logic [INDEX_W-1:0] index;
    logic               last;
  } coef_t;

  // Up to two coefficients per transaction; n counts them, e0 fills first.
  typedef struct packed {
    logic [1:0] n;
    coef_t      e0;
    coef_t      e1;
  } push_t;

endpackage

// ===== rtl/core/uniform_mod_q_rejection_sampler.sv =====
// Uniform mod-q rejection sampler: random bytes in, coefficients below the modulus out.
// Byte channel (byte_valid/byte_ready, rand_byte, start_req): one byte per transaction;
//   start_req marks the first byte of a new polynomial and clears byte phase and count.
// Coefficient channel (coeff_valid/coeff_ready, coeff, coeff_index, last): one accepted
//   coefficient per transaction; last marks the one reaching min(coeff_count, 256).
// Config port (cfg_we, cfg_idx, cfg_wdata): index 0 is modulus, 1 is coeff_count;
//   write only while the block is idle.
// Throughput: one byte per cycle while byte_ready is high; a third byte of a group
//   yields up to two coefficients, drained one per cycle while coeff_ready is high by
//   the output stage via a 4-entry queue. Each is queued when the third byte is taken,
//   then moved to the output register; the second of a pair follows the first.
// byte_ready drops when the queue cannot take a full pair, i.e. when the receiver has
//   stalled long enough to back the queue up; nothing is lost or reordered.
// After the count is reached, bytes are taken and dropped until a start_req.
// Reset: modulus 3329, coeff_count 256, phase and count cleared, queue and output empty.
module uniform_mod_q_rejection_sampler (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [umqrs_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [umqrs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                                byte_valid,
  output logic                                byte_ready,
  input  logic [umqrs_pkg::BYTE_W-1:0]        rand_byte,
  input  logic                                start_req,
  output logic                                coeff_valid,
  input  logic                                coeff_ready,
  output logic [umqrs_pkg::COEFF_W-1:0]       coeff,
  output logic [umqrs_pkg::INDEX_W-1:0]       coeff_index,
  output logic                                last
);

  umqrs_pkg::push_t push;
  umqrs_pkg::coef_t head;
  logic             room, pop, head_valid;

  umqrs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .rand_byte  (rand_byte),
    .start_req  (start_req),
    .room       (room),
    .push       (push)
  );

  umqrs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  umqrs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .coeff_valid (coeff_valid),
    .coeff_ready (coeff_ready),
    .coeff       (coeff),
    .coeff_index (coeff_index),
    .last        (last)
  );

endmodule

// ===== rtl/core/umqrs_front.sv =====
// Front end: config, byte grouping, candidate extraction, range check, indexing.
module umqrs_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [umqrs_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [umqrs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                 byte_valid,
  output logic                                 byte_ready,
  input  logic [umqrs_pkg::BYTE_W-1:0]         rand_byte,
  input  logic                                 start_req,
  input  logic                                 room,
  output umqrs_pkg::push_t                     push
);

  logic [umqrs_pkg::MOD_W-1:0]   modulus;
  logic [umqrs_pkg::CNT_W-1:0]   coeff_count;
  logic [umqrs_pkg::BYTE_W-1:0]  held [2];
  logic [1:0]                    phase;
  logic [umqrs_pkg::CNT_W-1:0]   cnt;

  logic [1:0]                    phase_next;
  logic [umqrs_pkg::CNT_W-1:0]   cnt_next;

  logic                          accept;
  logic [umqrs_pkg::CNT_W-1:0]   cnt0, cnt1, cnt2, lim;
  logic [1:0]                    ph0;
  logic                          done, third, ok1, ok2;
  logic [umqrs_pkg::COEFF_W-1:0] d1, d2;
  umqrs_pkg::coef_t              ea, eb;

  // no transaction is taken while reset is held
  assign byte_ready = room && !rst;
  assign accept     = byte_valid && byte_ready;

  always_comb begin
    cnt0  = start_req ? '0 : cnt;
    ph0   = start_req ? 2'd0 : phase;
    lim   = (32'(coeff_count) > umqrs_pkg::MAX_COEFFS) ?
            umqrs_pkg::CNT_W'(umqrs_pkg::MAX_COEFFS) : coeff_count;
    done  = cnt0 >= lim;
    third = ph0 >= 2'd2;   // phase 3 also counts as the third byte
    d1    = {held[1][3:0], held[0]};
    d2    = {rand_byte, held[1][7:4]};
    ok1   = {1'b0, d1} < modulus;
    cnt1  = cnt0 + umqrs_pkg::CNT_W'(ok1);
    ok2   = (cnt1 < lim) && ({1'b0, d2} < modulus);
    cnt2  = cnt1 + umqrs_pkg::CNT_W'(ok2);

    ea = '{coeff: d1, index: cnt0[umqrs_pkg::INDEX_W-1:0], last: (cnt1 == lim)};
    eb = '{coeff: d2, index: cnt1[umqrs_pkg::INDEX_W-1:0], last: (cnt2 == lim)};

    push.e0 = ok1 ? ea : eb;
    push.e1 = eb;
    if (accept && !done && third) begin
      push.n = {1'b0, ok1} + {1'b0, ok2};
    end else begin
      push.n = 2'd0;
    end

    if (done) begin
      cnt_next   = cnt0;
      phase_next = ph0;
    end else if (third) begin
      cnt_next   = cnt2;
      phase_next = 2'd0;
    end else begin
      cnt_next   = cnt0;
      phase_next = ph0 + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus     <= umqrs_pkg::MODULUS_RESET;
      coeff_count <= umqrs_pkg::COUNT_RESET;
      phase       <= 2'd0;
      cnt         <= '0;
      held[0]     <= '0;
      held[1]     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          umqrs_pkg::REG_MODULUS:     modulus     <= cfg_wdata;
          umqrs_pkg::REG_COEFF_COUNT: coeff_count <= cfg_wdata[umqrs_pkg::CNT_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        phase <= phase_next;
        cnt   <= cnt_next;
        if (!done && !third) begin
          held[ph0[0]] <= rand_byte;
        end
      end
    end
  end

endmodule

// ===== rtl/core/umqrs_queue.sv =====
// Small coefficient queue: two writes, one read per cycle.
`include "uniform_mod_q_rejection_sampler_assert.svh"

module umqrs_queue (
  input  logic              clk,
  input  logic              rst,
  input  umqrs_pkg::push_t  push,
  output logic              room,
  input  logic              pop,
  output logic              head_valid,
  output umqrs_pkg::coef_t  head
);

  umqrs_pkg::coef_t              mem [umqrs_pkg::QUEUE_DEPTH];
  logic [umqrs_pkg::QPTR_W-1:0]  wptr, rptr;
  logic [umqrs_pkg::QCNT_W-1:0]  count;
  logic [umqrs_pkg::QCNT_W-1:0]  count_next;
  logic [umqrs_pkg::QPTR_W-1:0]  wptr1;

  assign wptr1      = wptr + umqrs_pkg::QPTR_W'(1);
  assign head_valid = count != '0;
  assign head       = mem[rptr];
  // Front only proceeds when a full pair fits.
  assign room       = count <= umqrs_pkg::QCNT_W'(umqrs_pkg::QUEUE_DEPTH - 2);
  assign count_next = count + umqrs_pkg::QCNT_W'(push.n) - umqrs_pkg::QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wptr] <= push.e0;
    end
    if (push.n == 2'd2) begin
      mem[wptr1] <= push.e1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + umqrs_pkg::QPTR_W'(push.n);
      rptr  <= rptr + umqrs_pkg::QPTR_W'(pop);
      count <= count_next;
    end
  end

  `UMQRS_ASSERT_NOW(a_q_bound, 1'b1, count <= umqrs_pkg::QCNT_W'(umqrs_pkg::QUEUE_DEPTH), "queue count over depth")
  `UMQRS_ASSERT_NOW(a_q_no_underflow, pop, count != '0, "pop from empty queue")
  `UMQRS_ASSERT_NOW(a_q_pair_fits, push.n == 2'd2, room, "pair pushed without room")
  `UMQRS_ASSERT_NEXT(a_q_push_seen, (push.n != 2'd0) && !pop, count != '0, "pushed entry lost")

endmodule

// ===== rtl/core/umqrs_back.sv =====
// Back end: output register feeding the coefficient channel.
module umqrs_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            head_valid,
  input  umqrs_pkg::coef_t                head,
  output logic                            pop,
  output logic                            coeff_valid,
  input  logic                            coeff_ready,
  output logic [umqrs_pkg::COEFF_W-1:0]   coeff,
  output logic [umqrs_pkg::INDEX_W-1:0]   coeff_index,
  output logic                            last
);

  umqrs_pkg::coef_t out_reg;

  assign pop         = head_valid && (!coeff_valid || coeff_ready);
  assign coeff       = out_reg.coeff;
  assign coeff_index = out_reg.index;
  assign last        = out_reg.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_valid <= 1'b0;
    end else if (!coeff_valid || coeff_ready) begin
      coeff_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_reg <= head;
    end
  end

endmodule
